>>> rtl/core/mcsr_pkg.sv
// ----------------------------------------------------------------------------
// mcsr_pkg
// Shared types, constants and modular arithmetic for the size reduction core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mcsr_pkg;

  localparam int unsigned MAX_LEN = 1024;
  localparam int unsigned RES_W   = 63;
  localparam int unsigned IDX_W   = $clog2(MAX_LEN);
  localparam int unsigned LEN_W   = IDX_W + 1;
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned CFG_W   = 1;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_START = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  // Register indexes
  localparam logic [CFG_W-1:0] CFG_MODULUS = 1'b0;
  localparam logic [CFG_W-1:0] CFG_LENGTH  = 1'b1;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [IDX_W-1:0] index;
    logic [RES_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic [RES_W-1:0] element;
    logic             done_res;
  } out_word_t;

  // Buffer access request: one write and two reads
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [RES_W-1:0] wdata;
    logic [IDX_W-1:0] raddr_a;
    logic [IDX_W-1:0] raddr_b;
  } ram_req_t;

  // Sum with one conditional subtraction of p
  function automatic logic [RES_W-1:0] mod_add(input logic [RES_W-1:0] u,
                                                input logic [RES_W-1:0] v,
                                                input logic [RES_W-1:0] p);
    logic [RES_W:0] s;
    s = {1'b0, u} + {1'b0, v};
    if (s >= {1'b0, p}) s = s - {1'b0, p};
    return s[RES_W-1:0];
  endfunction

  // Difference, plus p on borrow
  function automatic logic [RES_W-1:0] mod_sub(input logic [RES_W-1:0] u,
                                                input logic [RES_W-1:0] v,
                                                input logic [RES_W-1:0] p);
    logic [RES_W:0] d;
    d = {1'b0, u} - {1'b0, v};
    if (u < v) d = d + {1'b0, p};
    return d[RES_W-1:0];
  endfunction

  // Highest set bit, one-hot
  function automatic logic [LEN_W-1:0] top_bit(input logic [LEN_W-1:0] x);
    logic [LEN_W-1:0] r;
    r = '0;
    for (int i = 0; i < LEN_W; i++) begin
      if (x[i]) r = LEN_W'(1) << i;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/mcsr_ram.sv
// ----------------------------------------------------------------------------
// mcsr_ram
// Generic memory: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mcsr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered reads
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

>>> rtl/core/mcsr_reducer.sv
// ----------------------------------------------------------------------------
// mcsr_reducer
// Sequencer for the in-place reduction: walks the set bits of the length,
// runs butterfly, fold and final subtraction steps through the buffer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mcsr_reducer import mcsr_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [LEN_W-1:0] length,
  input  wire logic [RES_W-1:0] modulus,
  input  wire logic [RES_W-1:0] rdata_a,
  input  wire logic [RES_W-1:0] rdata_b,
  output ram_req_t              req,
  output logic                  done
);

  localparam logic [2:0] R_IDLE = 3'd0;
  localparam logic [2:0] R_INIT = 3'd1;
  localparam logic [2:0] R_SEG  = 3'd2;
  localparam logic [2:0] R_RD   = 3'd3;
  localparam logic [2:0] R_WR1  = 3'd4;
  localparam logic [2:0] R_WR2  = 3'd5;
  localparam logic [2:0] R_DONE = 3'd6;

  logic [2:0]       state_r, state_nxt;
  logic [LEN_W-1:0] n_r, n_nxt;
  logic [LEN_W-1:0] nn_r, nn_nxt;
  logic [LEN_W-1:0] a_r, a_nxt;
  logic [LEN_W-1:0] b2_r, b2_nxt;
  logic [IDX_W-1:0] off_r, off_nxt;
  logic [IDX_W-1:0] t_r, t_nxt;
  logic             fin_r, fin_nxt;
  logic [RES_W-1:0] s1_r, s1_nxt;

  logic [LEN_W-1:0] a_top;
  logic [LEN_W-1:0] b_top;
  logic [IDX_W-1:0] addr_lo;
  logic [IDX_W-1:0] addr_hi;
  logic [IDX_W-1:0] addr_acc;
  logic [IDX_W-1:0] j_mask;
  logic             fold;
  logic             last_t;
  logic [LEN_W-1:0] off_ext;

  assign a_top    = top_bit(n_r);
  assign b_top    = top_bit(nn_r & (a_r - LEN_W'(1)));
  assign off_ext  = {1'b0, off_r};
  assign addr_lo  = off_r + t_r;
  assign addr_hi  = IDX_W'(off_ext + a_r + {1'b0, t_r});
  assign j_mask   = IDX_W'(b2_r - LEN_W'(1));
  assign addr_acc = IDX_W'(off_ext + a_r + {1'b0, (t_r & j_mask)});
  assign fold     = ({1'b0, t_r} >= b2_r);
  assign last_t   = ({1'b0, t_r} == (a_r - LEN_W'(1)));

  // Step control and buffer requests
  always_comb begin
    state_nxt   = state_r;
    n_nxt       = n_r;
    nn_nxt      = nn_r;
    a_nxt       = a_r;
    b2_nxt      = b2_r;
    off_nxt     = off_r;
    t_nxt       = t_r;
    fin_nxt     = fin_r;
    s1_nxt      = s1_r;
    req         = '0;
    done        = 1'b0;
    case (state_r)
      R_IDLE: begin
        if (start) begin
          if (length == '0) n_nxt = LEN_W'(1);
          else if (length > LEN_W'(MAX_LEN)) n_nxt = LEN_W'(MAX_LEN);
          else n_nxt = length;
          state_nxt = R_INIT;
        end
      end
      R_INIT: begin
        if (a_top == n_r) begin
          state_nxt = R_DONE;
        end else begin
          a_nxt     = a_top;
          nn_nxt    = n_r;
          off_nxt   = '0;
          state_nxt = R_SEG;
        end
      end
      R_SEG: begin
        t_nxt     = '0;
        fin_nxt   = (a_r == nn_r);
        b2_nxt    = b_top << 1;
        state_nxt = R_RD;
      end
      R_RD: begin
        req.raddr_a = addr_lo;
        req.raddr_b = addr_hi;
        state_nxt   = R_WR1;
      end
      R_WR1: begin
        req.we      = 1'b1;
        req.waddr   = addr_lo;
        req.wdata   = mod_sub(rdata_a, rdata_b, modulus);
        req.raddr_a = addr_acc;
        s1_nxt      = mod_add(rdata_a, rdata_b, modulus);
        if (fin_r) begin
          t_nxt     = t_r + IDX_W'(1);
          state_nxt = last_t ? R_DONE : R_RD;
        end else begin
          state_nxt = R_WR2;
        end
      end
      R_WR2: begin
        req.we = 1'b1;
        if (fold) begin
          req.waddr = addr_acc;
          req.wdata = mod_add(s1_r, rdata_a, modulus);
        end else begin
          req.waddr = addr_hi;
          req.wdata = s1_r;
        end
        if (last_t) begin
          // Move to the remainder segment
          off_nxt   = IDX_W'(off_ext + a_r);
          nn_nxt    = nn_r - a_r;
          a_nxt     = b2_r >> 1;
          state_nxt = R_SEG;
        end else begin
          t_nxt     = t_r + IDX_W'(1);
          state_nxt = R_RD;
        end
      end
      R_DONE: begin
        done      = 1'b1;
        state_nxt = R_IDLE;
      end
      default: state_nxt = R_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= R_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    n_r   <= n_nxt;
    nn_r  <= nn_nxt;
    a_r   <= a_nxt;
    b2_r  <= b2_nxt;
    off_r <= off_nxt;
    t_r   <= t_nxt;
    fin_r <= fin_nxt;
    s1_r  <= s1_nxt;
  end

  // Segment size is always a single power of two
  a_seg_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == R_SEG) |-> $onehot(a_r))
    else $error("segment size not a power of two");

  // Remaining length never drops below the current segment
  nn_cover: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == R_SEG) |-> (nn_r >= a_r))
    else $error("remaining length below segment size");

  // Step counter stays inside the segment
  t_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == R_RD) |-> ({1'b0, t_r} < a_r))
    else $error("step counter beyond segment");

endmodule

`default_nettype wire

>>> rtl/core/modular_cfft_size_reduction_core.sv
// ----------------------------------------------------------------------------
// modular_cfft_size_reduction_core
// Residue buffer with in-place truncated FFT size reduction modulo p.
// ----------------------------------------------------------------------------
// Usage:
//   in_word carries a command: write stores value at index (no result),
//   read returns the stored element, start reduces the first length
//   elements in place and answers one word with done_res set.
//   Command code three is dropped without a result.
//   cfg_we/cfg_index/cfg_data set modulus (index 0) and length (index 1);
//   write them only while the core is idle.
// Sequencing:
//   A read returns its element through the registered buffer read.
//   A start sets up in R_INIT, then runs each butterfly or fold step through
//   R_RD, R_WR1 and R_WR2, each final subtraction step through R_RD and R_WR1,
//   and each segment through R_SEG. All steps go through the single buffer write port one by one.
// Reset clears control state; the buffer holds nothing defined until written.
// While out_stall holds a result, in_stall stays high until it is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module modular_cfft_size_reduction_core import mcsr_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire in_word_t         in_word,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output out_word_t             out_word,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_index,
  input  wire logic [RES_W-1:0] cfg_data
);

  localparam logic [1:0] T_IDLE = 2'd0;
  localparam logic [1:0] T_READ = 2'd1;
  localparam logic [1:0] T_RED  = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [RES_W-1:0] modulus_r;
  logic [LEN_W-1:0] length_r;
  logic             out_valid_r;
  out_word_t        out_word_r;

  logic             in_take;
  logic             out_take;
  ram_req_t         host_req;
  ram_req_t         red_req;
  ram_req_t         ram_req;
  logic [RES_W-1:0] rdata_a;
  logic [RES_W-1:0] rdata_b;
  logic             red_start;
  logic             red_done;

  assign in_stall  = (state_r != T_IDLE) || (out_valid_r && out_stall);
  assign in_take   = in_valid && !in_stall;
  assign out_take  = out_valid_r && !out_stall;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign red_start = in_take && (in_word.command == CMD_START);

  // Host access to the buffer
  always_comb begin
    host_req         = '0;
    host_req.we      = in_take && (in_word.command == CMD_WRITE);
    host_req.waddr   = in_word.index;
    host_req.wdata   = in_word.value;
    host_req.raddr_a = in_word.index;
  end

  assign ram_req = (state_r == T_RED) ? red_req : host_req;

  mcsr_ram #(
    .WIDTH (RES_W),
    .DEPTH (MAX_LEN)
  ) u_buf (
    .clk     (clk),
    .we      (ram_req.we),
    .waddr   (ram_req.waddr),
    .wdata   (ram_req.wdata),
    .raddr_a (ram_req.raddr_a),
    .raddr_b (ram_req.raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  mcsr_reducer u_red (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (red_start),
    .length  (length_r),
    .modulus (modulus_r),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b),
    .req     (red_req),
    .done    (red_done)
  );

  // Command sequencing
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      T_IDLE: begin
        if (in_take && (in_word.command == CMD_READ)) state_nxt = T_READ;
        else if (red_start) state_nxt = T_RED;
      end
      T_READ: state_nxt = T_IDLE;
      T_RED: begin
        if (red_done) state_nxt = T_IDLE;
      end
      default: state_nxt = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      out_valid_r <= 1'b0;
      modulus_r   <= RES_W'(2);
      length_r    <= LEN_W'(1);
    end else begin
      state_r <= state_nxt;
      // Hold the result word until taken, load a new one when ready
      if (state_r == T_READ || (state_r == T_RED && red_done)) begin
        out_valid_r <= 1'b1;
      end else if (out_take) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we && cfg_index == CFG_MODULUS) modulus_r <= cfg_data;
      if (cfg_we && cfg_index == CFG_LENGTH)  length_r  <= cfg_data[LEN_W-1:0];
    end
    if (state_r == T_READ) begin
      out_word_r.element  <= rdata_a;
      out_word_r.done_res <= 1'b0;
    end else if (state_r == T_RED && red_done) begin
      out_word_r.element  <= '0;
      out_word_r.done_res <= 1'b1;
    end
  end

  // A read result only lands in a free or draining output slot
  slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == T_READ) |-> (!out_valid_r || !out_stall))
    else $error("read result would overwrite pending word");

  // Reduction completes only while the core is reducing
  done_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    red_done |-> (state_r == T_RED))
    else $error("reduction done outside reduce state");

  // Host writes never reach the buffer during a reduction
  no_host_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == T_RED) |-> !in_take)
    else $error("input accepted during reduction");

endmodule

`default_nettype wire

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the size reduction core: loads residue buffers,
// runs reductions over many moduli and lengths, reads back elements
// and compares each result word against an in-bench prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import mcsr_pkg::*;

  localparam logic [62:0] P_MAX = 63'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_word_t             in_word = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_word_t            out_word;
  logic                 cfg_we = 1'b0;
  logic [CFG_W-1:0]     cfg_index = '0;
  logic [RES_W-1:0]     cfg_data = '0;

  // Predicted block state
  logic [RES_W-1:0]     buf_model [0:MAX_LEN-1];
  logic [RES_W-1:0]     mod_p = 63'd2;
  logic [LEN_W-1:0]     len_n = 11'd1;
  out_word_t            pending_words [$];

  int                   errors = 0;
  int                   tx_idle_en = 1;
  int                   rx_idle_en = 1;
  int                   rx_hold = 0;
  int                   word_count = 0;

  modular_cfft_size_reduction_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Modular arithmetic, 64-bit intermediate, masked to the residue width
  function automatic logic [62:0] p_add(logic [62:0] u, logic [62:0] v);
    logic [63:0] s;
    s = {1'b0, u} + {1'b0, v};
    if (s >= {1'b0, mod_p}) s = s - {1'b0, mod_p};
    return s[62:0];
  endfunction

  function automatic logic [62:0] p_sub(logic [62:0] u, logic [62:0] v);
    logic [63:0] d;
    d = {1'b0, u} - {1'b0, v};
    if (u < v) d = d + {1'b0, mod_p};
    return d[62:0];
  endfunction

  // In-place reduction of the predicted buffer
  function automatic void reduce_buffer();
    int unsigned n, a, nn, off, t, b, b2, lambda, k, ell;
    logic [62:0] u, v;
    n = len_n;
    if (n == 0) n = 1;
    if (n > MAX_LEN) n = MAX_LEN;
    if (n <= 1) return;
    a = 1; k = 0; off = 0;
    while (a <= n / 2) begin
      k++;
      a = a << 1;
    end
    if (a == n) return;
    nn = n;
    while (a != nn) begin
      b = a >> 1;
      ell = k - 1;
      while ((nn & b) == 0) begin
        b = b >> 1;
        ell--;
      end
      b2 = b << 1;
      for (t = 0; t < b2; t++) begin
        u = buf_model[off + t];
        v = buf_model[off + a + t];
        buf_model[off + t] = p_sub(u, v);
        buf_model[off + a + t] = p_add(u, v);
      end
      lambda = 1 << (k - ell - 1);
      for (int unsigned i = 1; i < lambda; i++) begin
        for (int unsigned j = 0; j < b2; j++) begin
          u = buf_model[off + t];
          v = buf_model[off + a + t];
          buf_model[off + t] = p_sub(u, v);
          buf_model[off + a + j] = p_add(p_add(u, v), buf_model[off + a + j]);
          t++;
        end
      end
      off += a;
      nn -= a;
      a = b;
      k = ell;
    end
    for (t = 0; t < a; t++)
      buf_model[off + t] = p_sub(buf_model[off + t], buf_model[off + a + t]);
  endfunction

  // Apply one accepted word to the predicted state
  function automatic void predict_word(in_word_t w);
    out_word_t r;
    case (w.command)
      CMD_WRITE: begin
        buf_model[w.index] = w.value;
      end
      CMD_START: begin
        reduce_buffer();
        r.element = '0;
        r.done_res = 1'b1;
        pending_words.push_back(r);
      end
      CMD_READ: begin
        r.element = buf_model[w.index];
        r.done_res = 1'b0;
        pending_words.push_back(r);
      end
      default: ;
    endcase
  endfunction

  function automatic logic [62:0] rand63();
    return 63'({$urandom, $urandom});
  endfunction

  // Mostly proper residues, now and then any 63-bit value
  function automatic logic [62:0] gen_residue();
    if ($urandom_range(9) == 0) return rand63();
    return rand63() % mod_p;
  endfunction

  // Smallest power of two at or above the effective length
  function automatic int unsigned span_of(logic [LEN_W-1:0] l);
    int unsigned n, r;
    n = (l == 0) ? 1 : ((l > MAX_LEN) ? MAX_LEN : l);
    r = 1;
    while (r < n) r = r << 1;
    return r;
  endfunction

  // Offer one word, holding it until accepted; valid is left high
  task automatic send_word(logic [1:0] cmd, int unsigned idx, logic [62:0] val);
    in_word_t w;
    w.command = cmd;
    w.index = idx[IDX_W-1:0];
    w.value = val;
    if (tx_idle_en != 0 && $urandom_range(99) < 11) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_stall);
    predict_word(w);
    if (cmd != CMD_SPARE) word_count++;
  endtask

  task automatic stop_sending();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Pause until every result has come, then let trailing writes settle
  task automatic wait_idle();
    stop_sending();
    while (pending_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_W-1:0] idx, logic [62:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == CFG_MODULUS) mod_p = val;
    else len_n = val[LEN_W-1:0];
  endtask

  task automatic load_span(int unsigned span);
    for (int unsigned i = 0; i < span; i++) send_word(CMD_WRITE, i, gen_residue());
  endtask

  task automatic read_span(int unsigned span);
    for (int unsigned i = 0; i < span; i++) send_word(CMD_READ, i, rand63());
  endtask

  // Check each accepted result word; drive the receiver stall
  always @(posedge clk) begin
    out_word_t exp_w;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %h/%0b",
                 $realtime, out_word.element, out_word.done_res);
        errors++;
      end else begin
        exp_w = pending_words.pop_front();
        if (out_word.element !== exp_w.element) begin
          $display("%0t: element expected %h actual %h",
                   $realtime, exp_w.element, out_word.element);
          errors++;
        end
        if (out_word.done_res !== exp_w.done_res) begin
          $display("%0t: done_res expected %0b actual %0b",
                   $realtime, exp_w.done_res, out_word.done_res);
          errors++;
        end
      end
    end
    if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= (rx_idle_en != 0) && ($urandom_range(99) < 11);
    end
  end

  // Extremes, every command and the special lengths
  task automatic test_directed();
    write_reg(CFG_MODULUS, P_MAX);
    write_reg(CFG_LENGTH, 63'd5);
    send_word(CMD_WRITE, 0, 63'd0);
    send_word(CMD_WRITE, 1, P_MAX);
    send_word(CMD_WRITE, 2, P_MAX - 1);
    send_word(CMD_WRITE, 3, 63'd1);
    for (int unsigned i = 4; i < 8; i++) send_word(CMD_WRITE, i, rand63());
    send_word(CMD_WRITE, 1023, P_MAX);
    send_word(CMD_READ, 1023, 63'd0);
    send_word(CMD_SPARE, 0, P_MAX);
    send_word(CMD_START, 0, 63'd0);
    read_span(8);
    wait_idle();
    // powers of two, one and zero leave the buffer alone
    write_reg(CFG_LENGTH, 63'd8);
    send_word(CMD_START, 0, 63'd0);
    wait_idle();
    write_reg(CFG_LENGTH, 63'd1);
    send_word(CMD_START, 0, 63'd0);
    wait_idle();
    write_reg(CFG_LENGTH, 63'd0);
    write_reg(CFG_MODULUS, 63'd2);
    send_word(CMD_START, 0, 63'd0);
    wait_idle();
    write_reg(CFG_LENGTH, 63'd3);
    send_word(CMD_START, 0, 63'd0);
    read_span(4);
    wait_idle();
  endtask

  // Phases of load, mixed traffic and reduction under random settings
  task automatic test_random();
    int unsigned span, idx, sel, ops;
    while (word_count < 240) begin
      wait_idle();
      sel = $urandom_range(5);
      if (sel == 0) write_reg(CFG_MODULUS, 63'd2);
      else if (sel == 1) write_reg(CFG_MODULUS, P_MAX);
      else if (sel == 2) write_reg(CFG_MODULUS, 63'($urandom_range(1000, 2)));
      else write_reg(CFG_MODULUS, rand63() | 63'd2);
      write_reg(CFG_LENGTH, 63'($urandom_range(64, 1)));
      span = span_of(len_n);
      tx_idle_en = ($urandom_range(7) != 0);
      rx_idle_en = ($urandom_range(7) != 0);
      load_span(span);
      ops = $urandom_range(40, 10);
      for (int unsigned i = 0; i < ops; i++) begin
        sel = $urandom_range(99);
        idx = $urandom_range(span - 1);
        if (sel < 40) send_word(CMD_READ, idx, rand63());
        else if (sel < 70) send_word(CMD_WRITE, idx, gen_residue());
        else if (sel < 90) send_word(CMD_START, idx, rand63());
        else if (sel < 95) send_word(CMD_SPARE, $urandom_range(1023), rand63());
        else send_word(CMD_READ, 1023, rand63());
      end
      send_word(CMD_START, 0, 63'd0);
      read_span(span);
    end
    tx_idle_en = 1;
    rx_idle_en = 1;
    wait_idle();
  endtask

  // Long receiver hold while reads keep coming
  task automatic test_backpressure();
    rx_hold = 400;
    for (int unsigned i = 0; i < 40; i++) send_word(CMD_READ, i % 8, rand63());
    wait_idle();
  endtask

  // Full buffer with the largest lengths, saturation included
  task automatic test_full_length();
    write_reg(CFG_MODULUS, P_MAX - 24);
    load_span(MAX_LEN);
    wait_idle();
    write_reg(CFG_LENGTH, 63'd1000);
    send_word(CMD_START, 0, 63'd0);
    read_span(16);
    wait_idle();
    write_reg(CFG_LENGTH, 63'd2047);
    send_word(CMD_START, 0, 63'd0);
    wait_idle();
    write_reg(CFG_LENGTH, 63'd513);
    send_word(CMD_START, 0, 63'd0);
    wait_idle();
    write_reg(CFG_LENGTH, 63'd1023);
    send_word(CMD_START, 0, 63'd0);
    read_span(64);
    wait_idle();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random();
    test_full_length();
    repeat (50) @(posedge clk);
    if (errors == 0 && pending_words.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
